/* hw/rtl/i2c_bus_recovery_sequencer_defines.svh */
// ----------------------------------------------------------------------------
// I2C bus recovery sequencer assertion macros
// Shared implication checks, clocked on clock and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef I2C_BUS_RECOVERY_SEQUENCER_DEFINES_SVH
`define I2C_BUS_RECOVERY_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define BRS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("i2c_brs: same-cycle check failed");

// next-cycle implication
`define BRS_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("i2c_brs: next-cycle check failed");

`endif

/* hw/rtl/i2c_brs_pkg.sv */
// ----------------------------------------------------------------------------
// I2C bus recovery package
// Register layout, reset values, phase codes and CSR indexes.
// ----------------------------------------------------------------------------
package i2c_brs_pkg;

   localparam int SETTLE_W = 16;
   localparam int HALF_W   = 8;
   localparam int TIMER_W  = 20;
   localparam int PULSE_W  = 4;
   localparam int PHASE_W  = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam logic [SETTLE_W-1:0] SETTLE_RST = 16'd100;
   localparam logic [HALF_W-1:0]   HALF_RST   = 8'd5;
   localparam logic [TIMER_W-1:0]  LONG_RST   = 20'd50000;
   localparam logic [PULSE_W-1:0]  MAXP_RST   = 4'd9;

   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAXP   = 2'd3;

   localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
   localparam logic [PHASE_W-1:0] PH_SETTLE1 = 4'd1;
   localparam logic [PHASE_W-1:0] PH_PLOW    = 4'd2;
   localparam logic [PHASE_W-1:0] PH_PHIGH   = 4'd3;
   localparam logic [PHASE_W-1:0] PH_STOP    = 4'd4;
   localparam logic [PHASE_W-1:0] PH_SETTLE2 = 4'd5;
   localparam logic [PHASE_W-1:0] PH_LONG    = 4'd6;
   localparam logic [PHASE_W-1:0] PH_SETTLE3 = 4'd7;

   typedef struct packed {
      logic [SETTLE_W-1:0] settle_ticks;
      logic [HALF_W-1:0]   half_period_ticks;
      logic [TIMER_W-1:0]  long_low_ticks;
      logic [PULSE_W-1:0]  max_pulses;
   } cfg_type;

endpackage

/* hw/rtl/i2c_brs_if.sv */
// ----------------------------------------------------------------------------
// I2C bus recovery channels
// Request (tick or start) and response (line drive and status) handshakes.
// ----------------------------------------------------------------------------
interface i2c_brs_req_if;
   logic valid;
   logic ready;
   logic action;
   logic sda_level;
   logic scl_level;

   modport source (output valid, output action, output sda_level, output scl_level,
                   input ready);
   modport sink   (input valid, input action, input sda_level, input scl_level,
                   output ready);
endinterface

interface i2c_brs_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               scl_pull_low;
   logic                               sda_pull_low;
   logic                               busy_res;
   logic                               done_res;
   logic                               still_stuck;
   logic [i2c_brs_pkg::PULSE_W-1:0]    pulses_sent;

   modport source (output valid, output scl_pull_low, output sda_pull_low,
                   output busy_res, output done_res, output still_stuck,
                   output pulses_sent, input ready);
   modport sink   (input valid, input scl_pull_low, input sda_pull_low,
                   input busy_res, input done_res, input still_stuck,
                   input pulses_sent, output ready);
endinterface

/* hw/rtl/i2c_brs_csr.sv */
// ----------------------------------------------------------------------------
// I2C bus recovery configuration registers
// Write-only register bank, reset to the default timing.
// ----------------------------------------------------------------------------
module i2c_brs_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [i2c_brs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [i2c_brs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output i2c_brs_pkg::cfg_type                cfg
);

   i2c_brs_pkg::cfg_type cfg_ff;
   i2c_brs_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            i2c_brs_pkg::CSR_SETTLE:
               cfg_in.settle_ticks = csr_wdata[i2c_brs_pkg::SETTLE_W-1:0];
            i2c_brs_pkg::CSR_HALF:
               cfg_in.half_period_ticks = csr_wdata[i2c_brs_pkg::HALF_W-1:0];
            i2c_brs_pkg::CSR_LONG:
               cfg_in.long_low_ticks = csr_wdata[i2c_brs_pkg::TIMER_W-1:0];
            i2c_brs_pkg::CSR_MAXP:
               cfg_in.max_pulses = csr_wdata[i2c_brs_pkg::PULSE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_ticks      <= i2c_brs_pkg::SETTLE_RST;
         cfg_ff.half_period_ticks <= i2c_brs_pkg::HALF_RST;
         cfg_ff.long_low_ticks    <= i2c_brs_pkg::LONG_RST;
         cfg_ff.max_pulses        <= i2c_brs_pkg::MAXP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/i2c_brs_core.sv */
// ----------------------------------------------------------------------------
// I2C bus recovery core
// Input register, phase/timer state update and response register.
// ----------------------------------------------------------------------------
module i2c_brs_core (
   input  logic                  clock,
   input  logic                  reset,
   input  i2c_brs_pkg::cfg_type  cfg,
   i2c_brs_req_if.sink           req_chan,
   i2c_brs_rsp_if.source         rsp_chan
);

   localparam int TW = i2c_brs_pkg::TIMER_W;
   localparam int PW = i2c_brs_pkg::PULSE_W;

   // input stage
   logic in_valid_ff;
   logic in_action_ff, in_sda_ff, in_scl_ff;

   // sequence state
   logic [i2c_brs_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [TW-1:0]                   timer_ff, timer_in;
   logic [PW-1:0]                   pulse_ff, pulse_in;
   logic                            stuck_ff, stuck_in;
   logic                            done_in;

   // output stage
   logic          out_valid_ff;
   logic          out_scl_ff, out_sda_ff, out_busy_ff, out_done_ff, out_stuck_ff;
   logic [PW-1:0] out_pulses_ff;

   logic          out_free, fire;
   logic [TW-1:0] timer_inc;
   logic          settle_hit, half_hit, long_hit, pulse_go;

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign fire           = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   assign timer_inc  = timer_ff + {{(TW-1){1'b0}}, 1'b1};
   assign settle_hit = timer_ff >= {{(TW-i2c_brs_pkg::SETTLE_W){1'b0}}, cfg.settle_ticks};
   assign half_hit   = timer_inc >= {{(TW-i2c_brs_pkg::HALF_W){1'b0}}, cfg.half_period_ticks};
   assign long_hit   = timer_inc >= cfg.long_low_ticks;
   assign pulse_go   = (pulse_ff < cfg.max_pulses) && !in_sda_ff;

   always_comb begin
      phase_in = phase_ff;
      timer_in = timer_ff;
      pulse_in = pulse_ff;
      stuck_in = stuck_ff;
      done_in  = 1'b0;
      if (in_action_ff) begin
         if (phase_ff == i2c_brs_pkg::PH_IDLE) begin
            pulse_in = '0;
            stuck_in = 1'b0;
            phase_in = i2c_brs_pkg::PH_SETTLE1;
            timer_in = '0;
         end
      end else begin
         case (phase_ff)
            i2c_brs_pkg::PH_IDLE: begin
               timer_in = '0;
            end
            i2c_brs_pkg::PH_SETTLE1: begin
               if (settle_hit) begin
                  timer_in = '0;
                  if (!in_sda_ff && in_scl_ff && pulse_go) begin
                     pulse_in = pulse_ff + {{(PW-1){1'b0}}, 1'b1};
                     phase_in = i2c_brs_pkg::PH_PLOW;
                  end else begin
                     phase_in = i2c_brs_pkg::PH_SETTLE2;
                  end
               end else begin
                  timer_in = timer_inc;
               end
            end
            i2c_brs_pkg::PH_PLOW: begin
               timer_in = timer_inc;
               if (half_hit) begin
                  timer_in = '0;
                  phase_in = i2c_brs_pkg::PH_PHIGH;
               end
            end
            i2c_brs_pkg::PH_PHIGH: begin
               timer_in = timer_inc;
               if (half_hit) begin
                  timer_in = '0;
                  if (pulse_go) begin
                     pulse_in = pulse_ff + {{(PW-1){1'b0}}, 1'b1};
                     phase_in = i2c_brs_pkg::PH_PLOW;
                  end else if (in_sda_ff) begin
                     phase_in = i2c_brs_pkg::PH_STOP;
                  end else begin
                     phase_in = i2c_brs_pkg::PH_SETTLE2;
                  end
               end
            end
            i2c_brs_pkg::PH_STOP: begin
               timer_in = timer_inc;
               if (half_hit) begin
                  timer_in = '0;
                  phase_in = i2c_brs_pkg::PH_SETTLE2;
               end
            end
            i2c_brs_pkg::PH_SETTLE2: begin
               if (settle_hit) begin
                  timer_in = '0;
                  phase_in = (!in_sda_ff && in_scl_ff) ? i2c_brs_pkg::PH_LONG
                                                       : i2c_brs_pkg::PH_SETTLE3;
               end else begin
                  timer_in = timer_inc;
               end
            end
            i2c_brs_pkg::PH_LONG: begin
               timer_in = timer_inc;
               if (long_hit) begin
                  timer_in = '0;
                  phase_in = i2c_brs_pkg::PH_SETTLE3;
               end
            end
            i2c_brs_pkg::PH_SETTLE3: begin
               if (settle_hit) begin
                  timer_in = '0;
                  stuck_in = !in_sda_ff || !in_scl_ff;
                  done_in  = 1'b1;
                  phase_in = i2c_brs_pkg::PH_IDLE;
               end else begin
                  timer_in = timer_inc;
               end
            end
            default: begin
               timer_in = '0;
               phase_in = i2c_brs_pkg::PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= i2c_brs_pkg::PH_IDLE;
         timer_ff     <= '0;
         pulse_ff     <= '0;
         stuck_ff     <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            phase_ff <= phase_in;
            timer_ff <= timer_in;
            pulse_ff <= pulse_in;
            stuck_ff <= stuck_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_action_ff <= req_chan.action;
         in_sda_ff    <= req_chan.sda_level;
         in_scl_ff    <= req_chan.scl_level;
      end
      if (fire) begin
         out_scl_ff    <= (phase_in == i2c_brs_pkg::PH_PLOW) ||
                          (phase_in == i2c_brs_pkg::PH_LONG);
         out_sda_ff    <= phase_in == i2c_brs_pkg::PH_STOP;
         out_busy_ff   <= phase_in != i2c_brs_pkg::PH_IDLE;
         out_done_ff   <= done_in;
         out_stuck_ff  <= done_in && stuck_in;
         out_pulses_ff <= pulse_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.scl_pull_low = out_scl_ff;
   assign rsp_chan.sda_pull_low = out_sda_ff;
   assign rsp_chan.busy_res     = out_busy_ff;
   assign rsp_chan.done_res     = out_done_ff;
   assign rsp_chan.still_stuck  = out_stuck_ff;
   assign rsp_chan.pulses_sent  = out_pulses_ff;

endmodule

/* hw/rtl/i2c_bus_recovery_sequencer.sv */
// An accepted item passes the input register, then the result register, before
// its response item can be taken. Throughput: one item per cycle while the
// response side does not stall. A stalled response holds the result register;
// the input register takes one more item, then the request side stalls.
// Synchronous reset empties both stages, idles the sequence with all counts
// clear and restores default timing.
// ----------------------------------------------------------------------------
// I2C bus recovery sequencer
// Bus-clear sequence (settle, SCL pulses, STOP, long low hold) per tick item.
// ----------------------------------------------------------------------------
`include "i2c_bus_recovery_sequencer_defines.svh"

module i2c_bus_recovery_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   i2c_brs_req_if.sink                         req_chan,
   i2c_brs_rsp_if.source                       rsp_chan,
   input  logic                                csr_we,
   input  logic [i2c_brs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [i2c_brs_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   i2c_brs_pkg::cfg_type cfg;
   logic                 rsp_drive;

   i2c_brs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   i2c_brs_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   assign rsp_drive = rsp_chan.scl_pull_low || rsp_chan.sda_pull_low;

   `BRS_ASSERT_IMP(a_done_not_busy, rsp_chan.valid && rsp_chan.done_res, !rsp_chan.busy_res)
   `BRS_ASSERT_IMP(a_one_line_driven, rsp_chan.valid && rsp_chan.scl_pull_low, !rsp_chan.sda_pull_low)
   `BRS_ASSERT_IMP(a_drive_needs_busy, rsp_chan.valid && rsp_drive, rsp_chan.busy_res)
   `BRS_ASSERT_IMP(a_stuck_needs_done, rsp_chan.valid && rsp_chan.still_stuck, rsp_chan.done_res)

endmodule

/* bench/i2c_brs_checker.sv */
// ----------------------------------------------------------------------------
// I2C bus recovery sequencer checker
// Watches the request, response and CSR ports, runs its own model of the
// recovery sequence on every accepted item and compares each response item
// with the oldest predicted status.
// ----------------------------------------------------------------------------
module i2c_brs_checker
   import i2c_brs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   i2c_brs_req_if                req_mon,
   i2c_brs_rsp_if                rsp_mon,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   typedef struct packed {
      logic               scl_pull_low;
      logic               sda_pull_low;
      logic               busy;
      logic               done;
      logic               stuck;
      logic [PULSE_W-1:0] pulses;
   } line_status_type;

   cfg_type             timing;
   logic [PHASE_W-1:0]  seq_phase;
   logic [TIMER_W-1:0]  seq_timer;
   logic [PULSE_W-1:0]  seq_pulses;
   logic                seq_stuck;
   line_status_type     expected_status[$];
   line_status_type     observed;
   line_status_type     predicted;

   function automatic void enter_phase(input logic [PHASE_W-1:0] next_phase);
      seq_phase = next_phase;
      seq_timer = '0;
   endfunction

   function automatic logic timer_expired(input logic [TIMER_W-1:0] limit);
      seq_timer = seq_timer + 1'b1;
      return seq_timer >= limit;
   endfunction

   // settle decides on the tick after the count is reached
   function automatic logic settle_expired();
      if (seq_timer >= {{(TIMER_W-SETTLE_W){1'b0}}, timing.settle_ticks}) begin
         return 1'b1;
      end
      seq_timer = seq_timer + 1'b1;
      return 1'b0;
   endfunction

   function automatic void pulse_or_stop(input logic sda);
      if (seq_pulses < timing.max_pulses && !sda) begin
         seq_pulses = seq_pulses + 1'b1;
         enter_phase(PH_PLOW);
      end else if (sda) begin
         enter_phase(PH_STOP);
      end else begin
         enter_phase(PH_SETTLE2);
      end
   endfunction

   function automatic line_status_type advance_recovery(input logic act, input logic sda,
                                                        input logic scl);
      line_status_type st;
      logic            finished;
      finished = 1'b0;
      if (act) begin
         if (seq_phase == PH_IDLE) begin
            seq_pulses = '0;
            seq_stuck  = 1'b0;
            enter_phase(PH_SETTLE1);
         end
      end else begin
         case (seq_phase)
            PH_SETTLE1: begin
               if (settle_expired()) begin
                  if (!sda && scl) pulse_or_stop(sda);
                  else enter_phase(PH_SETTLE2);
               end
            end
            PH_PLOW: begin
               if (timer_expired({{(TIMER_W-HALF_W){1'b0}}, timing.half_period_ticks}))
                  enter_phase(PH_PHIGH);
            end
            PH_PHIGH: begin
               if (timer_expired({{(TIMER_W-HALF_W){1'b0}}, timing.half_period_ticks}))
                  pulse_or_stop(sda);
            end
            PH_STOP: begin
               if (timer_expired({{(TIMER_W-HALF_W){1'b0}}, timing.half_period_ticks}))
                  enter_phase(PH_SETTLE2);
            end
            PH_SETTLE2: begin
               if (settle_expired()) begin
                  if (!sda && scl) enter_phase(PH_LONG);
                  else enter_phase(PH_SETTLE3);
               end
            end
            PH_LONG: begin
               if (timer_expired(timing.long_low_ticks)) enter_phase(PH_SETTLE3);
            end
            PH_SETTLE3: begin
               if (settle_expired()) begin
                  seq_stuck = !sda || !scl;
                  finished  = 1'b1;
                  enter_phase(PH_IDLE);
               end
            end
            default: begin
               enter_phase(PH_IDLE);
            end
         endcase
      end
      st.scl_pull_low = (seq_phase == PH_PLOW) || (seq_phase == PH_LONG);
      st.sda_pull_low = (seq_phase == PH_STOP);
      st.busy         = (seq_phase != PH_IDLE);
      st.done         = finished;
      st.stuck        = finished & seq_stuck;
      st.pulses       = seq_pulses;
      return st;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         timing     = '{SETTLE_RST, HALF_RST, LONG_RST, MAXP_RST};
         seq_phase  = PH_IDLE;
         seq_timer  = '0;
         seq_pulses = '0;
         seq_stuck  = 1'b0;
         fail_count = 0;
         expected_status.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SETTLE: timing.settle_ticks      = csr_wdata[SETTLE_W-1:0];
               CSR_HALF:   timing.half_period_ticks = csr_wdata[HALF_W-1:0];
               CSR_LONG:   timing.long_low_ticks    = csr_wdata[TIMER_W-1:0];
               CSR_MAXP:   timing.max_pulses        = csr_wdata[PULSE_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_status.push_back(advance_recovery(req_mon.action, req_mon.sda_level,
                                                       req_mon.scl_level));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            observed = '{rsp_mon.scl_pull_low, rsp_mon.sda_pull_low, rsp_mon.busy_res,
                         rsp_mon.done_res, rsp_mon.still_stuck, rsp_mon.pulses_sent};
            if (expected_status.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: response item with nothing expected", $realtime);
               fail_count++;
            end else begin
               predicted = expected_status.pop_front();
               if (observed !== predicted) begin
                  if (fail_count < 10) begin
                     $display("%0t: status mismatch scl_low/sda_low/busy/done/stuck/pulses",
                              $realtime);
                     $display("   expected %b %b %b %b %b %0d", predicted.scl_pull_low,
                              predicted.sda_pull_low, predicted.busy, predicted.done,
                              predicted.stuck, predicted.pulses);
                     $display("   actual   %b %b %b %b %b %0d", observed.scl_pull_low,
                              observed.sda_pull_low, observed.busy, observed.done,
                              observed.stuck, observed.pulses);
                  end
                  fail_count++;
               end
            end
         end
      end
      pending = expected_status.size();
   end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// I2C bus recovery sequencer testbench
// Drives tick and start items shaped as stuck, released, noisy and clear
// bus conditions under several timing settings and idling modes; the
// checker beside the block predicts and compares every response item.
// ----------------------------------------------------------------------------
module tb_top;
   import i2c_brs_pkg::*;

   typedef enum int {
      SHAPE_RANDOM,
      SHAPE_RELEASE,
      SHAPE_STUCK,
      SHAPE_NOISE,
      SHAPE_SCL_LOW,
      SHAPE_CLEAR
   } line_shape_type;

   // {action, sda, scl}: pulses to the limit, long hold, clear bus, STOP
   localparam logic [0:25][2:0] OPENING_ITEMS = {
      3'b100, 3'b111, 3'b001, 3'b001, 3'b000, 3'b001, 3'b010, 3'b001, 3'b001,
      3'b001, 3'b011, 3'b001, 3'b000, 3'b010, 3'b100, 3'b011, 3'b011, 3'b000,
      3'b011, 3'b011, 3'b011, 3'b101, 3'b001, 3'b001, 3'b000, 3'b011
   };

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending;
   int                    src_idle_pct;
   int                    sink_stall_pct;
   int                    sink_hold;
   int                    items_sent;
   int                    sequences_run;
   int unsigned           cfg_settle;
   int unsigned           cfg_half;
   int unsigned           cfg_long;
   int unsigned           cfg_maxp;

   i2c_brs_req_if req_chan ();
   i2c_brs_rsp_if rsp_chan ();

   i2c_bus_recovery_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   i2c_brs_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(negedge clock) begin
      if (sink_hold > 0) begin
         sink_hold--;
         rsp_chan.ready = 1'b0;
      end else begin
         rsp_chan.ready = ($urandom_range(99) >= sink_stall_pct);
      end
   end

   initial begin
      #(8 * 2500000);
      $display("[i2c_bus_recovery_sequencer] ERROR");
      $finish;
   end

   task automatic send_item(input logic act, input logic sda, input logic scl);
      while ($urandom_range(99) < src_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid     = 1'b1;
      req_chan.action    = act;
      req_chan.sda_level = sda;
      req_chan.scl_level = scl;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_chan.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   task automatic set_timing(input int unsigned settle, input int unsigned half,
                             input int unsigned hold, input int unsigned maxp);
      wait_idle();
      write_reg(CSR_SETTLE, settle);
      write_reg(CSR_HALF, half);
      write_reg(CSR_LONG, hold);
      write_reg(CSR_MAXP, maxp);
      cfg_settle = settle;
      cfg_half   = half;
      cfg_long   = hold;
      cfg_maxp   = maxp;
   endtask

   // ticks that cover the longest sequence under the current timing
   function automatic int unsigned seq_budget();
      return 3 * (cfg_settle + 2) + (cfg_maxp + 1) * 2 * (cfg_half + 1) + cfg_long + 4;
   endfunction

   task automatic run_recovery(input line_shape_type shape_in, input int unsigned n_ticks,
                               input bit clean);
      line_shape_type shape;
      int unsigned    pick;
      int unsigned    release_at;
      int unsigned    i;
      logic           sda;
      logic           scl;
      bit             late_start;
      shape = shape_in;
      if (shape == SHAPE_RANDOM) begin
         pick = $urandom_range(9);
         if (pick < 5) shape = SHAPE_RELEASE;
         else if (pick < 7) shape = SHAPE_STUCK;
         else if (pick == 7) shape = SHAPE_NOISE;
         else if (pick == 8) shape = SHAPE_SCL_LOW;
         else shape = SHAPE_CLEAR;
      end
      release_at = $urandom_range(0, cfg_settle + 2 + (cfg_maxp + 1) * 2 * (cfg_half + 1));
      late_start = 1'b0;
      send_item(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
      sequences_run++;
      for (i = 0; i < n_ticks; i++) begin
         case (shape)
            SHAPE_RELEASE: begin sda = (i >= release_at); scl = 1'b1; end
            SHAPE_STUCK:   begin sda = 1'b0; scl = 1'b1; end
            SHAPE_NOISE: begin
               sda = 1'($urandom_range(1));
               scl = 1'($urandom_range(1));
            end
            SHAPE_SCL_LOW: begin
               sda = 1'($urandom_range(1));
               scl = ($urandom_range(3) == 0);
            end
            default:       begin sda = 1'b1; scl = 1'b1; end
         endcase
         if (!clean && shape != SHAPE_CLEAR) begin
            if ($urandom_range(99) < 3) sda = ~sda;
            // start while busy should be ignored; later ones may start a new run
            if ($urandom_range(99) < 3) begin
               send_item(1'b1, sda, scl);
               if (i > cfg_settle) late_start = 1'b1;
            end
         end
         send_item(1'b0, sda, scl);
      end
      if (late_start) begin
         for (i = 0; i < seq_budget(); i++) send_item(1'b0, 1'b1, 1'b1);
      end
   endtask

   initial begin
      int phase_no;
      int phase_first;
      int i;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.action    = 1'b0;
      req_chan.sda_level = 1'b1;
      req_chan.scl_level = 1'b1;
      rsp_chan.ready     = 1'b0;
      csr_we             = 1'b0;
      csr_index          = CSR_SETTLE;
      csr_wdata          = '0;
      src_idle_pct       = 0;
      sink_stall_pct     = 0;
      cfg_settle         = SETTLE_RST;
      cfg_half           = HALF_RST;
      cfg_long           = LONG_RST;
      cfg_maxp           = MAXP_RST;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset timing, bus clear so the long hold is skipped
      run_recovery(SHAPE_CLEAR, 3 * (cfg_settle + 2) + 8, 1'b1);

      set_timing(1, 1, 0, 2);
      for (i = 0; i < 26; i++)
         send_item(OPENING_ITEMS[i][2], OPENING_ITEMS[i][1], OPENING_ITEMS[i][0]);
      for (i = 0; i < seq_budget(); i++) send_item(1'b0, 1'b1, 1'b1);

      // zero half period and zero pulse limit
      set_timing(0, 0, 0, 0);
      run_recovery(SHAPE_STUCK, seq_budget(), 1'b1);
      run_recovery(SHAPE_RELEASE, seq_budget(), 1'b1);

      // full-scale timing: one whole low half at 255, then the widest settle and
      // long hold, left running until the next timing change shortens the run
      set_timing(0, 255, 0, 15);
      run_recovery(SHAPE_STUCK, 2 + 255 + 4, 1'b1);
      set_timing(65535, 1, 1048575, 1);
      run_recovery(SHAPE_CLEAR, 8, 1'b1);

      for (phase_no = 0; phase_no < 4; phase_no++) begin
         wait_idle();
         @(posedge clock);
         case (phase_no)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  sink_hold = 300; end
            1: begin src_idle_pct = 54; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 54; end
            default: begin src_idle_pct = 18; sink_stall_pct = 18; end
         endcase
         @(negedge clock);
         phase_first = items_sent;
         while (items_sent - phase_first < 130) begin
            set_timing($urandom_range(0, 4), $urandom_range(1, 3), $urandom_range(0, 12),
                       $urandom_range(1, 15));
            run_recovery(SHAPE_RANDOM, seq_budget(), 1'b0);
         end
      end

      req_chan.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      $display("Ran %0d items over %0d recovery sequences, timing from zero to full scale,",
               items_sent, sequences_run);
      $display("with and without idling on either side and one long response hold-off.");
      if (fail_count == 0 && pending == 0) begin
         $display("[i2c_bus_recovery_sequencer] OK");
      end else begin
         $display("[i2c_bus_recovery_sequencer] ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/i2c_brs_pkg.sv
hw/rtl/i2c_brs_if.sv
hw/rtl/i2c_brs_csr.sv
hw/rtl/i2c_brs_core.sv
hw/rtl/i2c_bus_recovery_sequencer.sv
bench/i2c_brs_checker.sv
bench/tb_top.sv
